/* hw/rtl/bgr_pkg.sv */
// Package for the bitmap glyph rasterizer: opcodes, register indexes, reset values,
// fixed field widths and the write beat shared between the top level and the store.
// Depends on nothing.
`default_nettype none

package bgr_pkg;

	// Fixed field widths.
	localparam int COLOR_W    = 16;
	localparam int INDEX_W    = 12;
	localparam int VALUE_W    = 16;
	localparam int OFFSET_W   = 12;
	localparam int CFG_IDX_W  = 3;
	// Byte address sum: 12-bit offset plus row times up to eight bytes plus byte number.
	localparam int ADDR_SUM_W = 14;
	// Bytes per glyph row: at most eight for any allowed glyph width.
	localparam int NB_W       = 4;

	// Parameter defaults.
	localparam int DEF_SCREEN_WIDTH    = 240;
	localparam int DEF_SCREEN_HEIGHT   = 135;
	localparam int DEF_FONT_BYTES      = 4096;
	localparam int DEF_MAX_GLYPHS      = 128;
	localparam int DEF_MAX_GLYPH_WIDTH = 32;

	// Register reset values.
	localparam logic [15:0] FG_RESET     = 16'hFFFF;
	localparam logic [15:0] BG_RESET     = 16'h0000;
	localparam logic [7:0]  COUNT_RESET  = 8'd128;
	localparam logic [7:0]  HEIGHT_RESET = 8'd8;

	typedef enum logic [2:0] {
		OP_LOAD_WIDTH  = 3'd0,
		OP_LOAD_OFFSET = 3'd1,
		OP_LOAD_FONT   = 3'd2,
		OP_START_ROW   = 3'd3,
		OP_DRAW        = 3'd4
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FG_COLOR     = 3'd0,
		CFG_BG_COLOR     = 3'd1,
		CFG_BOLD_ENABLE  = 3'd2,
		CFG_GLYPH_COUNT  = 3'd3,
		CFG_GLYPH_HEIGHT = 3'd4
	} cfg_index_t;

	// One table write as issued by the top level.
	typedef struct packed {
		logic               we_width;
		logic               we_offset;
		logic               we_font;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
	} bgr_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/bgr_store.sv */
// Glyph width table, glyph offset table and font byte store, each one write and
// one registered read port. Depends on bgr_pkg.
`default_nettype none

module bgr_store
	import bgr_pkg::*;
#(
	parameter int FONT_BYTES      = DEF_FONT_BYTES,
	parameter int MAX_GLYPHS      = DEF_MAX_GLYPHS,
	parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH,
	localparam int GI_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1,
	localparam int FA_W = $clog2(FONT_BYTES),
	localparam int WW   = $clog2(MAX_GLYPH_WIDTH + 1)
) (
	input  wire logic                clk,
	input  wire bgr_wr_t             wr,
	input  wire logic                rd_tbl_en,
	input  wire logic [GI_W-1:0]     rd_code,
	input  wire logic                rd_font_en,
	input  wire logic [FA_W-1:0]     rd_font_addr,
	output logic      [WW-1:0]       width_rd,
	output logic      [OFFSET_W-1:0] offset_rd,
	output logic      [7:0]          font_rd
);

	logic [WW-1:0]       width_mem  [MAX_GLYPHS];
	logic [OFFSET_W-1:0] offset_mem [MAX_GLYPHS];
	logic [7:0]          font_mem   [FONT_BYTES];

	logic [WW-1:0] width_sat;

	// Loaded widths saturate at the widest glyph the datapath supports.
	assign width_sat = (32'(wr.value) > MAX_GLYPH_WIDTH) ? WW'(MAX_GLYPH_WIDTH)
		: WW'(wr.value);

	always_ff @(posedge clk) begin
		if (wr.we_width) begin
			width_mem[GI_W'(wr.index)] <= width_sat;
		end
		if (wr.we_offset) begin
			offset_mem[GI_W'(wr.index)] <= wr.value[OFFSET_W-1:0];
		end
		if (wr.we_font) begin
			font_mem[FA_W'(wr.index)] <= wr.value[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_tbl_en) begin
			width_rd  <= width_mem[rd_code];
			offset_rd <= offset_mem[rd_code];
		end
		if (rd_font_en) begin
			font_rd <= font_mem[rd_font_addr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bitmap_glyph_rasterizer.sv */
// Bitmap font character generator, top level: register file, pen state and the
// per-glyph sequencer that walks the font bits one pixel per cycle within each font byte.
// Depends on bgr_pkg and bgr_store.
//
// Use: an item is taken on start while busy is low. Loads (width, offset, font
// byte) and the start-row item finish in the cycle they are taken and raise no
// busy; so does a draw item that is skipped (code or row out of range, pen row
// off screen). A drawn glyph raises busy and emits one pixel beat per cycle on
// pixel_valid, pausing for each font byte fetch, with last_pixel set on its final
// beat. The receiver cannot stall: each beat is on the ports for exactly one cycle.
// A draw item steps through the address sum on the table read (ST_ADDR), then for
// each font byte a read (ST_FETCH) and a load (ST_LOAD) followed by one pixel per
// bit (ST_PIX), and a last bold column (ST_BOLD) when bold is on; the pace is set
// by the single font store read port feeding a one-bit shifter. The first pixel
// beat is registered out of ST_PIX after ST_ADDR, ST_FETCH and ST_LOAD.
// Configuration is written on cfg_valid, always ready; the user must write it
// only while busy is low, which the block itself does not enforce.
// Reset sets the registers to their defaults and the pen to zero; the width,
// offset and font tables hold garbage until loaded.
`default_nettype none

module bitmap_glyph_rasterizer
	import bgr_pkg::*;
#(
	parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
	parameter int FONT_BYTES      = DEF_FONT_BYTES,
	parameter int MAX_GLYPHS      = DEF_MAX_GLYPHS,
	parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [2:0]           opcode,
	input  wire logic [INDEX_W-1:0]   table_index,
	input  wire logic [VALUE_W-1:0]   table_value,
	input  wire logic [8:0]           pen_x,
	input  wire logic [7:0]           pen_y,
	input  wire logic [7:0]           row_index,
	input  wire logic [7:0]           glyph_code,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	output logic                      pixel_valid,
	output logic [7:0]                pixel_x,
	output logic [7:0]                pixel_y,
	output logic [COLOR_W-1:0]        pixel_color,
	output logic                      last_pixel
);

	localparam int GI_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int FA_W = $clog2(FONT_BYTES);
	localparam int WW   = $clog2(MAX_GLYPH_WIDTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_FETCH,
		ST_LOAD,
		ST_PIX,
		ST_BOLD
	} state_t;

	state_t state_q;

	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               bold_q;
	logic [7:0]         gcount_q;
	logic [7:0]         gheight_q;

	logic [8:0] pen_col_q;
	logic [7:0] pen_row_q;
	logic [7:0] row_sel_q;

	logic [ADDR_SUM_W-1:0] addr_q;
	logic                  oob_q;
	logic [WW-1:0]         rem_q;
	logic [NB_W-1:0]       bit_cnt_q;
	logic [7:0]            db_q;
	logic                  prev_q;

	logic                  pix_valid_q;
	logic [7:0]            pix_x_q;
	logic [7:0]            pix_y_q;
	logic [COLOR_W-1:0]    pix_color_q;
	logic                  pix_last_q;

	logic          accept;
	logic          draw_ok;
	bgr_wr_t       wr;
	logic [WW-1:0]       width_rd;
	logic [OFFSET_W-1:0] offset_rd;
	logic [7:0]          font_rd;

	logic [WW:0]           width_rnd;
	logic [NB_W-1:0]       nbytes;
	logic [11:0]           row_off;
	logic [ADDR_SUM_W-1:0] base_addr;
	logic [9:0]            pen_nx;
	logic                  pen_end;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// A draw item renders only for a known code, a row inside the glyph and an
	// on-screen pen row.
	assign draw_ok = (opcode == OP_DRAW)
		&& (glyph_code < gcount_q)
		&& (32'(glyph_code) < MAX_GLYPHS)
		&& (row_sel_q < gheight_q)
		&& (32'(pen_row_q) < SCREEN_HEIGHT);

	always_comb begin
		wr.we_width  = accept && (opcode == OP_LOAD_WIDTH)
			&& (32'(table_index) < MAX_GLYPHS);
		wr.we_offset = accept && (opcode == OP_LOAD_OFFSET)
			&& (32'(table_index) < MAX_GLYPHS);
		wr.we_font   = accept && (opcode == OP_LOAD_FONT)
			&& (32'(table_index) < FONT_BYTES);
		wr.index     = table_index;
		wr.value     = table_value;
	end

	assign width_rnd = {1'b0, width_rd} + (WW+1)'(7);
	assign nbytes    = NB_W'(width_rnd >> 3);
	assign row_off   = 12'(row_sel_q) * 12'(nbytes);
	assign base_addr = ADDR_SUM_W'(offset_rd) + ADDR_SUM_W'(row_off);
	assign pen_nx    = {1'b0, pen_col_q} + 10'd1;
	assign pen_end   = (32'(pen_nx) >= SCREEN_WIDTH);

	bgr_store #(
		.FONT_BYTES      (FONT_BYTES),
		.MAX_GLYPHS      (MAX_GLYPHS),
		.MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
	) u_store (
		.clk          (clk),
		.wr           (wr),
		.rd_tbl_en    (accept),
		.rd_code      (GI_W'(glyph_code)),
		.rd_font_en   (state_q == ST_FETCH),
		.rd_font_addr (FA_W'(addr_q)),
		.width_rd     (width_rd),
		.offset_rd    (offset_rd),
		.font_rd      (font_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fg_q        <= FG_RESET;
			bg_q        <= BG_RESET;
			bold_q      <= 1'b0;
			gcount_q    <= COUNT_RESET;
			gheight_q   <= HEIGHT_RESET;
			pen_col_q   <= '0;
			pen_row_q   <= '0;
			row_sel_q   <= '0;
			addr_q      <= '0;
			oob_q       <= 1'b0;
			rem_q       <= '0;
			bit_cnt_q   <= '0;
			db_q        <= '0;
			prev_q      <= 1'b0;
			pix_valid_q <= 1'b0;
			pix_x_q     <= '0;
			pix_y_q     <= '0;
			pix_color_q <= '0;
			pix_last_q  <= 1'b0;
		end else begin
			pix_valid_q <= 1'b0;

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_FG_COLOR:     fg_q      <= cfg_data;
					CFG_BG_COLOR:     bg_q      <= cfg_data;
					CFG_BOLD_ENABLE:  bold_q    <= cfg_data[0];
					CFG_GLYPH_COUNT:  gcount_q  <= cfg_data[7:0];
					CFG_GLYPH_HEIGHT: gheight_q <= cfg_data[7:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_START_ROW) begin
							pen_col_q <= pen_x;
							pen_row_q <= pen_y;
							row_sel_q <= row_index;
						end else if (draw_ok) begin
							state_q <= ST_ADDR;
						end
					end
				end
				ST_ADDR: begin
					addr_q <= base_addr;
					rem_q  <= width_rd;
					prev_q <= 1'b0;
					if (32'(pen_col_q) >= SCREEN_WIDTH) begin
						state_q <= ST_IDLE;
					end else if (width_rd == '0) begin
						state_q <= bold_q ? ST_BOLD : ST_IDLE;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					// Bytes past the end of the store read as zero.
					oob_q   <= (32'(addr_q) >= FONT_BYTES);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					db_q      <= oob_q ? 8'd0 : font_rd;
					bit_cnt_q <= (32'(rem_q) > 8) ? NB_W'(8) : NB_W'(rem_q);
					state_q   <= ST_PIX;
				end
				ST_PIX: begin
					pix_valid_q <= 1'b1;
					pix_x_q     <= pen_col_q[7:0];
					pix_y_q     <= pen_row_q;
					pix_color_q <= (db_q[0] || (bold_q && prev_q)) ? fg_q : bg_q;
					pix_last_q  <= pen_end || ((rem_q == WW'(1)) && !bold_q);
					pen_col_q   <= pen_nx[8:0];
					prev_q      <= db_q[0];
					db_q        <= db_q >> 1;
					rem_q       <= rem_q - WW'(1);
					bit_cnt_q   <= bit_cnt_q - NB_W'(1);
					if (pen_end) begin
						state_q <= ST_IDLE;
					end else if (rem_q == WW'(1)) begin
						state_q <= bold_q ? ST_BOLD : ST_IDLE;
					end else if (bit_cnt_q == NB_W'(1)) begin
						addr_q  <= addr_q + ADDR_SUM_W'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_BOLD: begin
					// The pen is known to be on screen here.
					pix_valid_q <= 1'b1;
					pix_x_q     <= pen_col_q[7:0];
					pix_y_q     <= pen_row_q;
					pix_color_q <= prev_q ? fg_q : bg_q;
					pix_last_q  <= 1'b1;
					pen_col_q   <= pen_nx[8:0];
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pixel_valid = pix_valid_q;
	assign pixel_x     = pix_x_q;
	assign pixel_y     = pix_y_q;
	assign pixel_color = pix_color_q;
	assign last_pixel  = pix_last_q;

endmodule

`default_nettype wire
